@@ hw/rtl/lrups_pkg.sv @@
// lrups_pkg: shared constants and types for the lru page stack
// used by lrups_cell and lru_page_replacement_stack_core; no dependencies
package lrups_pkg;

   // built depth of the stack and width of a stored page
   localparam int FRAMES    = 16;
   localparam int PAGE_BITS = 16;

   // width of the occupancy count, which must hold FRAMES itself
   localparam int CNT_W = $clog2(FRAMES + 1);

   // port field widths
   localparam int PAGE_W  = 16;
   localparam int FAULT_W = 32;
   localparam int LIM_W   = 5;

   // frames_in_use after reset
   localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(16);

   // per-cell control from the top level
   typedef struct packed {
      logic update;    // a request is being taken this cycle
      logic any_hit;   // the request page is somewhere in the stack
      logic full;      // no free frame, a miss evicts the bottom
      logic valid;     // this cell lies below the occupancy count
      logic below_top; // a valid cell that has a valid cell above it
      logic is_top;    // the most recent valid cell
      logic is_free;   // the first cell above the occupied stack
   } cell_ctrl_type;

endpackage

@@ hw/rtl/lrups_cell.sv @@
// lrups_cell: one entry of the lru page stack with its own comparator
// depends on lrups_pkg
module lrups_cell (
   input  logic                             clock,
   input  lrups_pkg::cell_ctrl_type         ctrl,
   input  logic [lrups_pkg::PAGE_BITS-1:0]  req_page,
   input  logic [lrups_pkg::PAGE_BITS-1:0]  above_page,
   input  logic                             seen_in,
   output logic                             seen_out,
   output logic [lrups_pkg::PAGE_BITS-1:0]  page
);

   logic [lrups_pkg::PAGE_BITS-1:0] page_ff;
   logic [lrups_pkg::PAGE_BITS-1:0] page_in;
   logic                            hit_here;

   // compare against the request and pass the match on upwards
   assign hit_here = ctrl.valid && (page_ff == req_page);
   assign seen_out = seen_in || hit_here;
   assign page     = page_ff;

   // next entry: new page on top, fill a free slot, or take the one above
   always_comb begin
      page_in = page_ff;
      if (ctrl.update) begin
         if (ctrl.is_top && (ctrl.any_hit || ctrl.full)) begin
            page_in = req_page;
         end else if (ctrl.is_free && !ctrl.any_hit && !ctrl.full) begin
            page_in = req_page;
         end else if (ctrl.below_top && ((ctrl.full && !ctrl.any_hit) || seen_out)) begin
            page_in = above_page;
         end
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

endmodule

@@ hw/rtl/lru_page_replacement_stack_core.sv @@
// LRU page replacement stack: a row of lrups_cell entries, least recent at
// the bottom (cell 0), with occupancy, fault counter and result register.
// Each request carries one page number and returns one response: hit flag,
// evicted flag and page, and the saturating fault total. Every cell compares
// the request in parallel and the stack shifts by one in the same cycle, so a
// request is taken each cycle unless stalled; its response is registered in
// the result register, and a new request is taken whenever that register is
// empty or being read. frames_in_use (0 acts as 1, above 16 as 16) may be
// written only while no request is outstanding. Depends on lrups_pkg.
module lru_page_replacement_stack_core (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wen,
   input  logic [4:0]  csr_wdata,  // frames_in_use
   // requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] page_number
   // responses
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata   // [0] hit, [1] evicted_valid,
                                   // [17:2] evicted_page, [49:18] fault_count
);

   localparam int N = lrups_pkg::FRAMES;
   localparam int CW = lrups_pkg::CNT_W;
   localparam int PB = lrups_pkg::PAGE_BITS;
   localparam int FW = lrups_pkg::FAULT_W;

   logic [lrups_pkg::LIM_W-1:0]  frames_ff, frames_in;
   logic [CW-1:0]                occ_ff, occ_in;
   logic [FW-1:0]                fault_ff, fault_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         hit_ff, hit_in;
   logic                         ev_valid_ff, ev_valid_in;
   logic [lrups_pkg::PAGE_W-1:0] ev_page_ff, ev_page_in;

   logic [CW-1:0]                lim;
   logic                         take;
   logic                         any_hit;
   logic                         full;
   logic [PB-1:0]                req_page;
   lrups_pkg::cell_ctrl_type     ctrl [N];
   logic [PB-1:0]                cell_page [N];
   logic [PB-1:0]                above [N];
   logic                         seen [N+1];

   assign req_page   = PB'(req_tdata);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   // clamp the configured frame count into 1..FRAMES
   always_comb begin
      if (frames_ff == '0) begin
         lim = CW'(1);
      end else if (CW'(frames_ff) > CW'(N) || 32'(frames_ff) > N) begin
         lim = CW'(N);
      end else begin
         lim = CW'(frames_ff);
      end
   end

   assign full    = (occ_ff >= lim);
   assign any_hit = seen[N];
   assign seen[0] = 1'b0;

   // per-cell position against the occupancy count
   always_comb begin
      for (int k = 0; k < N; k++) begin
         ctrl[k].update    = take;
         ctrl[k].any_hit   = any_hit;
         ctrl[k].full      = full;
         ctrl[k].valid     = CW'(k) < occ_ff;
         ctrl[k].below_top = CW'(k + 1) < occ_ff;
         ctrl[k].is_top    = CW'(k + 1) == occ_ff;
         ctrl[k].is_free   = CW'(k) == occ_ff;
      end
   end

   // the row of cells, each fed by its upper neighbour
   for (genvar g = 0; g < N; g++) begin : g_cell
      if (g == N - 1) begin : g_last
         assign above[g] = '0;
      end else begin : g_mid
         assign above[g] = cell_page[g+1];
      end
      lrups_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[g]),
         .req_page   (req_page),
         .above_page (above[g]),
         .seen_in    (seen[g]),
         .seen_out   (seen[g+1]),
         .page       (cell_page[g])
      );
   end

   // occupancy, fault counter and result register next values
   always_comb begin
      frames_in    = frames_ff;
      occ_in       = occ_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      hit_in       = hit_ff;
      ev_valid_in  = ev_valid_ff;
      ev_page_in   = ev_page_ff;
      if (csr_wen) begin
         frames_in = csr_wdata;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
         hit_in       = any_hit;
         ev_valid_in  = !any_hit && full;
         ev_page_in   = (!any_hit && full) ? lrups_pkg::PAGE_W'(cell_page[0]) : '0;
         if (!any_hit) begin
            if (!full) begin
               occ_in = occ_ff + CW'(1);
            end
            if (fault_ff != '1) begin
               fault_in = fault_ff + FW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff    <= lrups_pkg::LIM_RESET;
         occ_ff       <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frames_ff    <= frames_in;
         occ_ff       <= occ_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      hit_ff      <= hit_in;
      ev_valid_ff <= ev_valid_in;
      ev_page_ff  <= ev_page_in;
   end

   // fault_count is taken after the update, so it rides with fault_ff
   logic [FW-1:0] rsp_fault_ff;
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_fault_ff <= fault_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_fault_ff, ev_page_ff, ev_valid_ff, hit_ff};

endmodule
